FILE: rtl/core/clsr_pkg.sv
// shared types and constants of the combined lcg shuffle generator
// generator constants, step handshake structs and the sequencer state enum
// no dependencies
package clsr_pkg;

  // generator one
  localparam logic [30:0] MOD1 = 31'd2147483563;
  localparam logic [15:0] MUL1 = 16'd40014;
  localparam logic [15:0] QUO1 = 16'd53668;
  localparam logic [15:0] REM1 = 16'd12211;

  // generator two
  localparam logic [30:0] MOD2 = 31'd2147483399;
  localparam logic [15:0] MUL2 = 16'd40692;
  localparam logic [15:0] QUO2 = 16'd52774;
  localparam logic [15:0] REM2 = 16'd3791;

  // reciprocal of the schrage quotient, scaled by 2^RECIP_SHIFT
  localparam int          RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP1 = 32'((64'd1 << RECIP_SHIFT) / 64'd53668);
  localparam logic [31:0] RECIP2 = 32'((64'd1 << RECIP_SHIFT) / 64'd52774);

  localparam logic [31:0] FIRST_RESET  = 32'd1;
  localparam logic [30:0] SECOND_RESET = 31'd123456789;

  // shuffle table
  localparam int          TABLE_DEPTH   = 32;
  localparam int          TABLE_IDX_W   = 5;
  localparam int          REBUILD_STEPS = 40;
  localparam logic [30:0] TABLE_DIV     = 31'(64'd1 + (64'd2147483563 - 64'd1) / 64'd32);
  localparam logic [30:0] WRAP_ADD      = 31'd2147483562;
  localparam logic [30:0] MAG_MAX       = 31'h7fffffff;

  // generator select of a step unit
  localparam logic GEN_ONE = 1'b0;
  localparam logic GEN_TWO = 1'b1;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct packed {
    logic        start;
    logic [30:0] seed;
  } step_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] value;
  } step_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REB_LAUNCH,
    ST_REB_WAIT,
    ST_DRAW_LAUNCH,
    ST_DRAW_WAIT,
    ST_DELIVER
  } state_t;

endpackage

FILE: rtl/core/clsr_ram.sv
// generic single write port ram with registered read
// no dependencies
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/clsr_step.sv
// six stage schrage step of one lehmer generator
// uses clsr_pkg for generator constants and the step structs
module clsr_step import clsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      gen_sel,
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [31:0] recip;
  logic [15:0] quo;
  logic [15:0] mul;
  logic [15:0] rem;
  logic [30:0] modv;

  always_comb begin
    case (gen_sel)
      GEN_ONE: begin
        recip = RECIP1;
        quo   = QUO1;
        mul   = MUL1;
        rem   = REM1;
        modv  = MOD1;
      end
      default: begin
        recip = RECIP2;
        quo   = QUO2;
        mul   = MUL2;
        rem   = REM2;
        modv  = MOD2;
      end
    endcase
  end

  logic [5:0]  vld;
  logic [62:0] prod0;
  logic [15:0] k0, k1, k2, k3;
  logic [30:0] s0, s1;
  logic [31:0] m1;
  logic [31:0] diff2;
  logic [15:0] r2;
  logic [31:0] a3, a4;
  logic [31:0] b4;
  logic [32:0] t5;
  logic [30:0] val;

  assign prod0 = 63'(req.seed) * 63'(recip);
  assign diff2 = 32'(s1) - m1;
  assign t5    = {1'b0, a4} - {1'b0, b4};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    // quotient estimate, low by at most one
    k0 <= prod0[RECIP_SHIFT +: 16];
    s0 <= req.seed;
    m1 <= 32'(k0) * 32'(quo);
    k1 <= k0;
    s1 <= s0;
    // correct the estimate
    if (diff2 >= 32'(quo)) begin
      r2 <= 16'(diff2 - 32'(quo));
      k2 <= k1 + 16'd1;
    end else begin
      r2 <= diff2[15:0];
      k2 <= k1;
    end
    a3 <= 32'(mul) * 32'(r2);
    k3 <= k2;
    b4 <= 32'(k3) * 32'(rem);
    a4 <= a3;
    if (t5[32]) begin
      val <= 31'(t5 + 33'(modv));
    end else begin
      val <= t5[30:0];
    end
  end

  assign rsp.done  = vld[5];
  assign rsp.value = val;

endmodule

FILE: rtl/core/combined_lcg_shuffle_rng_core.sv
// combined lcg generator with 32 entry shuffle table, top level
// uses clsr_pkg, clsr_step (schrage step pipeline) and clsr_ram (shuffle table)
// draw: an accepted word passes the check, launch and wait states and then deliver before the result is valid;
//   a new word is taken only back in idle, and deliver waits while the output word waits on out_ready
// reseed: warm-up draws, plus a table rebuild of 40 steps when generator one is not positive
// each draw and rebuild step runs through the 6 stage step pipeline between its launch and wait states
// reset: generators and last output to reset values, table valid bits cleared
module combined_lcg_shuffle_rng_core import clsr_pkg::*; #(
  parameter int WARMUP_DRAWS = 29
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] random_value
);

  localparam int WARM_W = (WARMUP_DRAWS > 1) ? $clog2(WARMUP_DRAWS + 1) : 1;

  state_t state, state_next;

  // generator state and last output, kept in flops
  logic [31:0]            g1;
  logic [30:0]            g2;
  logic [30:0]            last;
  logic [TABLE_DEPTH-1:0] tbl_valid;

  // sequencing
  logic [WARM_W-1:0]      warm_cnt;
  logic                   silent;
  logic [5:0]             reb_n;
  logic [TABLE_IDX_W-1:0] idx;
  logic                   hit;

  // step units
  step_req_t req1, req2;
  step_rsp_t rsp1, rsp2;

  // table port
  logic                   ram_we;
  logic [TABLE_IDX_W-1:0] ram_waddr;
  logic                   ram_re;
  logic [30:0]            ram_rdata;

  logic in_take;
  assign in_take = in_valid && in_ready;

  // generator one non-positive means the table is rebuilt first
  logic g1_nonpos;
  assign g1_nonpos = g1[31] || (g1 == 32'd0);

  // magnitude of the seed, saturated to 2^31-1, at least one
  logic [31:0] g1_neg;
  logic [30:0] mag;
  assign g1_neg = 32'd0 - g1;
  always_comb begin
    if (g1 == 32'h80000000) begin
      mag = MAG_MAX;
    end else if (g1 == 32'd0) begin
      mag = 31'd1;
    end else begin
      mag = g1_neg[30:0];
    end
  end

  // table index: last / TABLE_DIV, estimate by shift, fix by one compare
  logic [TABLE_IDX_W-1:0] q_est;
  logic [5:0]             q_inc;
  logic [32:0]            q_limit;
  logic [TABLE_IDX_W-1:0] idx_c;
  assign q_est   = last[30:26];
  assign q_inc   = 6'(q_est) + 6'd1;
  assign q_limit = 33'(q_inc) * 33'(TABLE_DIV);
  assign idx_c   = (33'(last) >= q_limit) ? q_inc[TABLE_IDX_W-1:0] : q_est;

  // shuffled output: entry minus generator two, wrapped below one
  logic [30:0]        entry;
  logic signed [32:0] diff_c;
  logic [30:0]        last_draw;
  assign entry     = hit ? ram_rdata : 31'd0;
  assign diff_c    = $signed({2'b00, entry}) - $signed({2'b00, rsp2.value});
  assign last_draw = (diff_c < 33'sd1) ? 31'(diff_c + 33'(WRAP_ADD)) : diff_c[30:0];

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (cmd == CMD_RESEED && WARMUP_DRAWS == 0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_next = g1_nonpos ? ST_REB_LAUNCH : ST_DRAW_LAUNCH;
      end
      ST_REB_LAUNCH: begin
        state_next = ST_REB_WAIT;
      end
      ST_REB_WAIT: begin
        if (rsp1.done) begin
          state_next = (reb_n == 6'd0) ? ST_DRAW_LAUNCH : ST_REB_LAUNCH;
        end
      end
      ST_DRAW_LAUNCH: begin
        state_next = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        if (rsp1.done) begin
          if (!silent) begin
            state_next = ST_DELIVER;
          end else if (warm_cnt == WARM_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    req1.start = 1'b0;
    req2.start = 1'b0;
    req1.seed  = g1[30:0];
    req2.seed  = g2;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_REB_LAUNCH: begin
        req1.start = 1'b1;
      end
      ST_REB_WAIT: begin
        // only the last 32 steps land in the table, entry 31 first
        ram_we    = rsp1.done && (reb_n < 6'(TABLE_DEPTH));
        ram_waddr = reb_n[TABLE_IDX_W-1:0];
      end
      ST_DRAW_LAUNCH: begin
        req1.start = 1'b1;
        req2.start = 1'b1;
        ram_re     = 1'b1;
      end
      ST_DRAW_WAIT: begin
        // refill the entry just read; next read comes cycles later, no overlap
        ram_we = rsp1.done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      g1        <= FIRST_RESET;
      g2        <= SECOND_RESET;
      last      <= '0;
      tbl_valid <= '0;
      warm_cnt  <= '0;
      silent    <= 1'b0;
      reb_n     <= '0;
      idx       <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new word loaded in the deliver state takes the place of the one leaving
      if (out_valid && out_ready && state != ST_DELIVER) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (cmd == CMD_RESEED) begin
              g1       <= seed_value;
              silent   <= 1'b1;
              warm_cnt <= WARM_W'(WARMUP_DRAWS);
            end else begin
              silent <= 1'b0;
            end
          end
        end
        ST_CHECK: begin
          if (g1_nonpos) begin
            g1    <= {1'b0, mag};
            g2    <= mag;
            reb_n <= 6'(REBUILD_STEPS - 1);
          end
        end
        ST_REB_WAIT: begin
          if (rsp1.done) begin
            g1 <= {1'b0, rsp1.value};
            if (reb_n < 6'(TABLE_DEPTH)) begin
              tbl_valid[reb_n[TABLE_IDX_W-1:0]] <= 1'b1;
            end
            if (reb_n == 6'd0) begin
              last <= rsp1.value;
            end else begin
              reb_n <= reb_n - 6'd1;
            end
          end
        end
        ST_DRAW_LAUNCH: begin
          idx <= idx_c;
          hit <= tbl_valid[idx_c];
        end
        ST_DRAW_WAIT: begin
          if (rsp1.done) begin
            g1             <= {1'b0, rsp1.value};
            g2             <= rsp2.value;
            last           <= last_draw;
            tbl_valid[idx] <= 1'b1;
            if (silent) begin
              warm_cnt <= warm_cnt - WARM_W'(1);
            end
          end
        end
        ST_DELIVER: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && out_free) begin
      random_value <= last;
    end
  end

  clsr_step u_step1 (
    .clk     (clk),
    .rst     (rst),
    .gen_sel (GEN_ONE),
    .req     (req1),
    .rsp     (rsp1)
  );

  clsr_step u_step2 (
    .clk     (clk),
    .rst     (rst),
    .gen_sel (GEN_TWO),
    .req     (req2),
    .rsp     (rsp2)
  );

  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rsp1.value),
    .re    (ram_re),
    .raddr (idx_c),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // generator two only ever steps alongside generator one
  a_step_pair: assert property (@(posedge clk) disable iff (rst)
    rsp2.done |-> rsp1.done)
    else $error("generator two step finished without generator one");

  // a delivered word lies in the output range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER) |-> (last != 31'd0 && last <= WRAP_ADD))
    else $error("shuffled output out of range");

  // warm-up draws never run with an exhausted count
  a_warm_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_WAIT && silent) |-> (warm_cnt != '0))
    else $error("warm-up draw with zero count");

  // an accepted word keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && (cmd == CMD_DRAW || WARMUP_DRAWS != 0)) |=> !in_ready)
    else $error("input taken again before the word was processed");
`endif

endmodule

FILE: test/combined_lcg_shuffle_rng_core_tb.sv
// testbench for combined_lcg_shuffle_rng_core: draw and reseed words with random gaps and stalls
// holds its own model of both generators and the shuffle table, checks every output word
// depends on clsr_pkg and the rtl of combined_lcg_shuffle_rng_core
module combined_lcg_shuffle_rng_core_tb import clsr_pkg::*;;

  localparam int WARMUP      = 29;
  localparam int STALL_LIMIT = 4000;  // well above the time a rebuild plus warm-up runs
  localparam int SETTLE      = 600;   // lets a trailing reseed finish before the end

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [31:0] seed_value;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] random_value;

  // model state of the generator
  int          gen_one;
  logic [30:0] gen_two;
  logic [30:0] prev_out;
  logic [30:0] shuffle_tab [TABLE_DEPTH];

  logic [30:0] expected_values [$];
  int          error_count;
  int          quiet_cycles;
  bit          sender_calm;
  bit          receiver_calm;

  combined_lcg_shuffle_rng_core #(
    .WARMUP_DRAWS(WARMUP)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_value(random_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one schrage step, s below 2^31
  function automatic longint lehmer_step(longint s, longint mul, longint quo, longint rem,
                                         longint modulus);
    longint k;
    longint t;
    k = s / quo;
    t = mul * (s - k * quo) - k * rem;
    if (t < 0) t += modulus;
    return t;
  endfunction

  function automatic longint step_gen_one(longint s);
    return lehmer_step(s, longint'(MUL1), longint'(QUO1), longint'(REM1), longint'(MOD1));
  endfunction

  // advances both generators, swaps one table entry and returns the new output
  function automatic logic [30:0] draw_value();
    longint mag;
    longint diff;
    longint g2;
    int     idx;
    if (gen_one <= 0) begin
      // non-positive generator one: rebuild the table from its magnitude
      mag = -longint'(gen_one);
      if (mag > 64'sd2147483647) mag = 64'sd2147483647;
      if (mag < 1) mag = 1;
      gen_one = int'(mag);
      gen_two = mag[30:0];
      for (int n = REBUILD_STEPS - 1; n >= 0; n--) begin
        gen_one = int'(step_gen_one(longint'(gen_one)));
        if (n < TABLE_DEPTH) shuffle_tab[n] = gen_one[30:0];
      end
      prev_out = shuffle_tab[0];
    end
    gen_one = int'(step_gen_one(longint'(gen_one)));
    g2 = lehmer_step(longint'(gen_two), longint'(MUL2), longint'(QUO2), longint'(REM2),
                     longint'(MOD2));
    gen_two = g2[30:0];
    idx = int'((longint'(prev_out) / longint'(TABLE_DIV)) & (TABLE_DEPTH - 1));
    diff = longint'(shuffle_tab[idx]) - g2;
    shuffle_tab[idx] = gen_one[30:0];
    if (diff < 1) diff += longint'(MOD1) - 1;
    prev_out = diff[30:0];
    return prev_out;
  endfunction

  // effect of one accepted word on the model
  task automatic apply_word(input logic c, input logic [31:0] seed);
    if (c == CMD_RESEED) begin
      gen_one = int'($signed(seed));
      repeat (WARMUP) void'(draw_value());
    end else begin
      expected_values.push_back(draw_value());
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // sends one word, holding valid until the handshake completes
  task automatic send_word(input logic c, input logic [31:0] seed);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    seed_value <= seed;
    do @(posedge clk); while (!in_ready);
    apply_word(c, seed);
  endtask

  task automatic send_draw();
    send_word(CMD_DRAW, $urandom());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  // the table is still all zeros right after reset
  task automatic test_draws_from_reset();
    repeat (4) send_draw();
  endtask

  // seed corners: positive keeps the table, zero and negative rebuild it
  task automatic test_reseed_corners();
    send_word(CMD_RESEED, 32'd1);
    send_draw();
    send_word(CMD_RESEED, 32'd0);
    send_draw();
    send_draw();
    send_word(CMD_RESEED, 32'hffff_ffff);
    send_draw();
    send_word(CMD_RESEED, 32'h8000_0000);  // magnitude saturates
    send_draw();
    send_word(CMD_RESEED, 32'h8000_0001);
    send_draw();
    send_word(CMD_RESEED, 32'h7fff_ffff);
    send_draw();
    send_word(CMD_RESEED, 32'h5555_aaaa);
    send_word(CMD_RESEED, 32'haaaa_5555);  // back to back reseeds
    send_draw();
  endtask

  // sender holds off until every pending word has come out
  task automatic test_pause_for_drain();
    repeat (6) send_draw();
    wait_drained();
    repeat (3) send_draw();
  endtask

  // mostly draws, now and then a reseed of either sign
  task automatic test_random_traffic(input int count);
    logic [31:0] seed;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 4) begin
        seed = $urandom();
        case ($urandom_range(0, 3))
          0: seed[31] = 1'b1;
          1: seed = {1'b0, seed[30:0]} % 32'd1000;  // small non-negative seed
          default: ;
        endcase
        send_word(CMD_RESEED, seed);
      end else begin
        send_draw();
      end
    end
  endtask

  // output side: random stalls, check each word against the oldest prediction
  initial begin
    logic [30:0] want;
    int          stall;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected word random_value=%0d", random_value));
      end else begin
        want = expected_values.pop_front();
        if (random_value !== want)
          report_mismatch($sformatf("random_value got %0d want %0d", random_value, want));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout at %0t", $realtime);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    error_count   = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_DRAW;
    seed_value <= '0;
    // model reset state
    gen_one  = int'(FIRST_RESET);
    gen_two  = SECOND_RESET;
    prev_out = '0;
    foreach (shuffle_tab[i]) shuffle_tab[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_draws_from_reset();
    test_reseed_corners();
    test_pause_for_drain();
    test_random_traffic(1820);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
